>>> hdl/dwmf_pkg.sv
// Shared word types and command codes for the dictionary word masking filter.
`timescale 1ns / 1ps

package dwmf_pkg;

  // Command codes carried by an input word
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_WORD  = 2'd1;
  localparam logic [1:0] CMD_MSG   = 2'd2;

  // Mask character after reset ('*')
  localparam logic [7:0] MASK_RESET = 8'd42;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_value;
    logic       is_last;
  } dwmf_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
  } dwmf_out_t;

endpackage

>>> hdl/dwmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dwmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/dwmf_match.sv
// Shared comparator: checks one dictionary row against the tail of the window.
`timescale 1ns / 1ps

module dwmf_match #(
  parameter int MAX_WORD_LEN = 16,
  localparam int WIN_LEN     = MAX_WORD_LEN - 1,
  localparam int CNT_W       = $clog2(MAX_WORD_LEN + 1),
  localparam int RW          = WIN_LEN * 8
) (
  input  logic               en,
  input  logic [RW-1:0]      win_chars,
  input  logic [CNT_W-1:0]   win_cnt,
  input  logic [RW-1:0]      row_chars,
  input  logic [CNT_W-1:0]   row_len,
  output logic [WIN_LEN-1:0] set_mask
);

  logic [CNT_W-1:0]   start;
  logic [RW-1:0]      aligned;
  logic [WIN_LEN-1:0] eq;
  logic               hit;

  // Line the word up so that its last byte sits on the newest window byte
  assign start   = win_cnt - row_len;
  assign aligned = row_chars << {start, 3'b000};

  genvar j;
  generate
    for (j = 0; j < WIN_LEN; j++) begin : g_pos
      localparam logic [CNT_W-1:0] JV = CNT_W'(j);
      logic in_rng;
      assign in_rng = (JV >= start) && (JV < win_cnt);
      assign eq[j]  = !in_rng || (win_chars[j*8 +: 8] == aligned[j*8 +: 8]);
    end
  endgenerate

  assign hit = en && (row_len <= win_cnt) && (row_len >= CNT_W'(2)) && (&eq);

  // Mark every matched byte after the first
  generate
    for (j = 0; j < WIN_LEN; j++) begin : g_mask
      localparam logic [CNT_W-1:0] JM = CNT_W'(j);
      assign set_mask[j] = hit && (JM > start) && (JM < win_cnt);
    end
  endgenerate

endmodule

>>> hdl/dictionary_word_masking_filter.sv
// Top level: dictionary loader, message window and match sequencer.
`timescale 1ns / 1ps

// Dictionary word masking filter. Command CLEAR and dictionary-word commands
// are handled in the idle state without holding the input off. A message
// word holds the input off through the insert and match states. After the
// insert step one dictionary row (all bytes plus its length) is read from the
// word RAM per cycle, for each stored dictionary word, and checked by a single
// shared comparator against the window tail in the cycle after its read. The
// sequencer then returns to idle, or to the flush state for a word marked
// last. When the evicted byte must go out, the insert step also waits for the
// output register to be free. The flush sends the bytes still held in the
// window (up to MAX_WORD_LEN-1) oldest first, one per cycle while the output
// register is free. Input is not accepted while a message word is in work. No
// clearing pass is needed after reset.
module dictionary_word_masking_filter #(
  parameter int NUM_WORDS    = 16,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dwmf_pkg::dwmf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dwmf_pkg::dwmf_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  import dwmf_pkg::*;

  localparam int WIN_LEN = MAX_WORD_LEN - 1;
  localparam int CNT_W   = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int WC_W    = $clog2(NUM_WORDS + 1);
  localparam int WI_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int RW      = WIN_LEN * 8;
  localparam int ROW_W   = RW + CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_MATCH  = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  logic [1:0]         state_r,   state_nxt;
  dwmf_in_t           item_r,    item_nxt;
  logic [RW-1:0]      win_r,     win_nxt;
  logic [WIN_LEN-1:0] msk_r,     msk_nxt;
  logic [CNT_W-1:0]   cnt_r,     cnt_nxt;
  logic [WC_W-1:0]    wcnt_r,    wcnt_nxt;
  logic [CNT_W-1:0]   lpos_r,    lpos_nxt;
  logic               ldrop_r,   ldrop_nxt;
  logic [RW-1:0]      lbuf_r,    lbuf_nxt;
  logic [WC_W-1:0]    iss_r,     iss_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  dwmf_out_t          out_r,     out_nxt;
  logic [7:0]         mask_r;

  logic               out_free;
  logic               ld_drop;
  logic [CNT_W-1:0]   ld_pos_after;
  logic [RW-1:0]      ld_row;
  logic               ld_commit;
  logic               ram_we;
  logic               ram_rd_en;
  logic [ROW_W-1:0]   ram_rd_data;
  logic [WIN_LEN-1:0] set_mask;
  logic [7:0]         head_char;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign out_free  = !out_vld_r || out_ready;
  assign head_char = msk_r[0] ? mask_r : win_r[7:0];

  // Dictionary load: decide whether this byte is kept and whether the word commits
  assign ld_drop = ldrop_r || (wcnt_r >= WC_W'(NUM_WORDS)) || (lpos_r >= CNT_W'(WIN_LEN));
  assign ld_pos_after = ld_drop ? lpos_r : (lpos_r + 1'b1);
  assign ld_commit    = !ld_drop && (ld_pos_after >= CNT_W'(2));

  always_comb begin
    ld_row = lbuf_r;
    if (!ld_drop) begin
      ld_row[{lpos_r[IDX_W-1:0], 3'b000} +: 8] = in_data.char_value;
    end
  end

  // Word rows: stored bytes with the word length on top
  dwmf_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_WORDS)
  ) u_word_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(wcnt_r[WI_W-1:0]),
    .wr_data({ld_pos_after, ld_row}),
    .rd_en  (ram_rd_en),
    .rd_addr(iss_r[WI_W-1:0]),
    .rd_data(ram_rd_data)
  );

  dwmf_match #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_match (
    .en       (cmp_vld_r),
    .win_chars(win_r),
    .win_cnt  (cnt_r),
    .row_chars(ram_rd_data[RW-1:0]),
    .row_len  (ram_rd_data[RW +: CNT_W]),
    .set_mask (set_mask)
  );

  // Sequencer and datapath next state
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    win_nxt     = win_r;
    msk_nxt     = msk_r;
    cnt_nxt     = cnt_r;
    wcnt_nxt    = wcnt_r;
    lpos_nxt    = lpos_r;
    ldrop_nxt   = ldrop_r;
    lbuf_nxt    = lbuf_r;
    iss_nxt     = iss_r;
    cmp_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r && !out_ready;
    out_nxt     = out_r;
    ram_we      = 1'b0;
    ram_rd_en   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          case (in_data.command)
            CMD_CLEAR: begin
              wcnt_nxt  = '0;
              lpos_nxt  = '0;
              ldrop_nxt = 1'b0;
            end
            CMD_WORD: begin
              lbuf_nxt = ld_row;
              if (in_data.is_last) begin
                if (ld_commit) begin
                  ram_we   = 1'b1;
                  wcnt_nxt = wcnt_r + 1'b1;
                end
                lpos_nxt  = '0;
                ldrop_nxt = 1'b0;
              end else begin
                lpos_nxt  = ld_pos_after;
                ldrop_nxt = ld_drop;
              end
            end
            CMD_MSG: begin
              state_nxt = ST_INSERT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_INSERT: begin
        if (cnt_r == CNT_W'(WIN_LEN)) begin
          // Window full: evict the oldest byte, then append
          if (out_free) begin
            out_nxt.char_out = head_char;
            out_nxt.last_out = 1'b0;
            out_vld_nxt      = 1'b1;
            win_nxt          = win_r >> 8;
            win_nxt[(WIN_LEN-1)*8 +: 8] = item_r.char_value;
            msk_nxt          = msk_r >> 1;
            iss_nxt          = '0;
            state_nxt        = ST_MATCH;
          end
        end else begin
          win_nxt[{cnt_r[IDX_W-1:0], 3'b000} +: 8] = item_r.char_value;
          msk_nxt[cnt_r[IDX_W-1:0]] = 1'b0;
          cnt_nxt   = cnt_r + 1'b1;
          iss_nxt   = '0;
          state_nxt = ST_MATCH;
        end
      end

      ST_MATCH: begin
        // Issue one row read per cycle; compare the row read last cycle
        msk_nxt = msk_r | set_mask;
        if (iss_r < wcnt_r) begin
          ram_rd_en   = 1'b1;
          iss_nxt     = iss_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end else if (!cmp_vld_r) begin
          state_nxt = item_r.is_last ? ST_FLUSH : ST_IDLE;
        end
      end

      ST_FLUSH: begin
        // Drain the window oldest first
        if (out_free) begin
          out_nxt.char_out = head_char;
          out_nxt.last_out = (cnt_r == CNT_W'(1));
          out_vld_nxt      = 1'b1;
          win_nxt          = win_r >> 8;
          msk_nxt          = msk_r >> 1;
          cnt_nxt          = cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      msk_r     <= '0;
      cnt_r     <= '0;
      wcnt_r    <= '0;
      lpos_r    <= '0;
      ldrop_r   <= 1'b0;
      iss_r     <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      msk_r     <= msk_nxt;
      cnt_r     <= cnt_nxt;
      wcnt_r    <= wcnt_nxt;
      lpos_r    <= lpos_nxt;
      ldrop_r   <= ldrop_nxt;
      iss_r     <= iss_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    win_r  <= win_nxt;
    lbuf_r <= lbuf_nxt;
    out_r  <= out_nxt;
  end

  // Mask character register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_wr_data;
    end
  end

  // A message word keeps the block busy on the next cycle
  a_msg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.command == CMD_MSG)) |=> !in_ready)
    else $error("input taken while a message word is in work");

  // The window never holds more than its length
  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WIN_LEN))
    else $error("window count overflow");

  // The dictionary never holds more than its capacity
  a_dict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= WC_W'(NUM_WORDS))
    else $error("word count overflow");

  // Sending the final byte empties the window
  a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && out_free && (cnt_r == CNT_W'(1)))
      |=> ((cnt_r == '0) && out_valid && out_data.last_out))
    else $error("window not empty after final byte");

  // The matcher only runs while the sequencer is matching
  a_cmp_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == ST_MATCH))
    else $error("comparison outside match phase");

endmodule
